// ===== src/ple_pkg.sv =====
// Package for the positional list engine: widths, command, status and state codes.
// No dependencies; used by ple_ctrl, positional_list_engine and the testbench.
package ple_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CMD_W        = 3;
  localparam int unsigned POS_W        = 5;
  localparam int unsigned LEN_W        = 5;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned LEN_MAX      = 31;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_GET    = 3'd2,
    CMD_LOCATE = 3'd3,
    CMD_CLEAR  = 3'd4
  } ple_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } ple_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS_SHIFT,
    S_INS_PUT,
    S_SCAN
  } ple_state_e;

endpackage

// ===== src/ple_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module ple_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ple_ctrl.sv =====
// Command sequencer for the positional list engine: length register, shift and scan
// pipelines over the entry RAM, result registers. Depends on ple_pkg.
module ple_ctrl #(
  parameter int unsigned CAPACITY = ple_pkg::CAPACITY_DEF,
  localparam int unsigned AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [ple_pkg::CMD_W-1:0]     command_i,
  input  logic [ple_pkg::POS_W-1:0]     position_i,
  input  logic [ple_pkg::DATA_W-1:0]    value_i,
  output logic                          done_o,
  output logic [ple_pkg::STATUS_W-1:0]  status_o,
  output logic [ple_pkg::DATA_W-1:0]    data_out_o,
  output logic [ple_pkg::LEN_W-1:0]     found_at_o,
  output logic [ple_pkg::LEN_W-1:0]     count_o,
  output logic                          ram_we_o,
  output logic [AW-1:0]                 ram_waddr_o,
  output logic [ple_pkg::DATA_W-1:0]    ram_wdata_o,
  output logic [AW-1:0]                 ram_raddr_o,
  input  logic [ple_pkg::DATA_W-1:0]    ram_rdata_i
);

  localparam int unsigned LIMIT_I = (CAPACITY < ple_pkg::LEN_MAX) ? CAPACITY : ple_pkg::LEN_MAX;
  localparam logic [ple_pkg::LEN_W-1:0] Limit = ple_pkg::LEN_W'(LIMIT_I);

  ple_pkg::ple_state_e  state_q, state_d;
  ple_pkg::ple_cmd_e    cmd_q, cmd_d;
  logic [ple_pkg::LEN_W-1:0]    len_q, len_d;
  logic [ple_pkg::LEN_W-1:0]    n_q, n_d;
  logic [AW-1:0]                ptr_q, ptr_d;
  logic [AW-1:0]                pa_q, pa_d;
  logic [AW-1:0]                put_q, put_d;
  logic                         pend_q, pend_d;
  logic                         first_q, first_d;
  logic                         hit_q, hit_d;
  logic                         done_q, done_d;
  logic [ple_pkg::DATA_W-1:0]   val_q, val_d;
  logic [ple_pkg::DATA_W-1:0]   data_q, data_d;
  logic [ple_pkg::LEN_W-1:0]    found_q, found_d;
  ple_pkg::ple_status_e         status_q, status_d;

  logic [ple_pkg::POS_W:0]      pos_x;
  logic [ple_pkg::POS_W:0]      len_x;
  logic [ple_pkg::LEN_W-1:0]    tail_n;

  assign pos_x  = {1'b0, position_i};
  assign len_x  = {1'b0, len_q};
  assign tail_n = len_q - position_i + ple_pkg::LEN_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ple_pkg::S_IDLE;
      len_q   <= '0;
      done_q  <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      done_q  <= done_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    n_q      <= n_d;
    ptr_q    <= ptr_d;
    pa_q     <= pa_d;
    put_q    <= put_d;
    first_q  <= first_d;
    hit_q    <= hit_d;
    val_q    <= val_d;
    data_q   <= data_d;
    found_q  <= found_d;
    status_q <= status_d;
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    n_d         = n_q;
    ptr_d       = ptr_q;
    pa_d        = pa_q;
    put_d       = put_q;
    pend_d      = pend_q;
    first_d     = first_q;
    hit_d       = hit_q;
    done_d      = 1'b0;
    val_d       = val_q;
    data_d      = data_q;
    found_d     = found_q;
    status_d    = status_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = pa_q;
    ram_wdata_o = ram_rdata_i;
    ram_raddr_o = ptr_q;

    case (state_q)
      ple_pkg::S_IDLE: begin
        if (start) begin
          cmd_d    = ple_pkg::ple_cmd_e'(command_i);
          val_d    = value_i;
          data_d   = '0;
          found_d  = '0;
          status_d = ple_pkg::ST_OK;
          pend_d   = 1'b0;
          first_d  = 1'b1;
          hit_d    = 1'b0;
          case (command_i)
            ple_pkg::CMD_INSERT: begin
              if (position_i == '0 || pos_x > len_x + 6'd1) begin
                status_d = ple_pkg::ST_BAD_POS;
                done_d   = 1'b1;
              end else if (len_q >= Limit) begin
                status_d = ple_pkg::ST_FULL;
                done_d   = 1'b1;
              end else begin
                ptr_d   = AW'(len_q - ple_pkg::LEN_W'(1));
                n_d     = tail_n;
                put_d   = AW'(position_i - ple_pkg::POS_W'(1));
                state_d = ple_pkg::S_INS_SHIFT;
              end
            end
            ple_pkg::CMD_DELETE, ple_pkg::CMD_GET: begin
              if (position_i == '0 || pos_x > len_x) begin
                status_d = ple_pkg::ST_BAD_POS;
                done_d   = 1'b1;
              end else begin
                ptr_d   = AW'(position_i - ple_pkg::POS_W'(1));
                n_d     = (command_i == ple_pkg::CMD_DELETE) ? tail_n : ple_pkg::LEN_W'(1);
                state_d = ple_pkg::S_SCAN;
              end
            end
            ple_pkg::CMD_LOCATE: begin
              ptr_d   = '0;
              n_d     = len_q;
              state_d = ple_pkg::S_SCAN;
            end
            ple_pkg::CMD_CLEAR: begin
              len_d  = '0;
              done_d = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      // reads walk down from the tail, each word lands one slot higher
      ple_pkg::S_INS_SHIFT: begin
        if (pend_q) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = pa_q + AW'(1);
        end
        if (n_q != '0) begin
          pa_d   = ptr_q;
          ptr_d  = ptr_q - AW'(1);
          n_d    = n_q - ple_pkg::LEN_W'(1);
          pend_d = 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = ple_pkg::S_INS_PUT;
        end
      end

      ple_pkg::S_INS_PUT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = put_q;
        ram_wdata_o = val_q;
        len_d       = len_q + ple_pkg::LEN_W'(1);
        done_d      = 1'b1;
        state_d     = ple_pkg::S_IDLE;
      end

      // ascending reads: first word is get/delete result, delete moves rest down
      ple_pkg::S_SCAN: begin
        if (pend_q) begin
          first_d = 1'b0;
          if (first_q && cmd_q != ple_pkg::CMD_LOCATE) begin
            data_d = ram_rdata_i;
          end
          if (cmd_q == ple_pkg::CMD_DELETE && !first_q) begin
            ram_we_o    = 1'b1;
            ram_waddr_o = pa_q - AW'(1);
          end
          if (cmd_q == ple_pkg::CMD_LOCATE && !hit_q && ram_rdata_i == val_q) begin
            hit_d   = 1'b1;
            found_d = ple_pkg::LEN_W'(pa_q) + ple_pkg::LEN_W'(1);
          end
        end
        if (n_q != '0) begin
          pa_d   = ptr_q;
          ptr_d  = ptr_q + AW'(1);
          n_d    = n_q - ple_pkg::LEN_W'(1);
          pend_d = 1'b1;
        end else begin
          pend_d  = 1'b0;
          done_d  = 1'b1;
          state_d = ple_pkg::S_IDLE;
          if (cmd_q == ple_pkg::CMD_LOCATE) begin
            status_d = hit_d ? ple_pkg::ST_OK : ple_pkg::ST_NOT_FOUND;
          end
          if (cmd_q == ple_pkg::CMD_DELETE) begin
            len_d = len_q - ple_pkg::LEN_W'(1);
          end
        end
      end

      default: begin
        state_d = ple_pkg::S_IDLE;
      end
    endcase
  end

  assign busy       = (state_q != ple_pkg::S_IDLE);
  assign done_o     = done_q;
  assign status_o   = status_q;
  assign data_out_o = data_q;
  assign found_at_o = found_q;
  assign count_o    = len_q;

endmodule

// ===== src/positional_list_engine.sv =====
// Top level of the positional list engine: command sequencer plus entry RAM.
// Depends on ple_pkg, ple_ram, ple_ctrl.
//
// A command is taken when start is high and busy is low; its single result appears
// on the result ports for one cycle with done_o, and must be taken then since the
// receiver cannot stall. For 1-based position p: insert moves words p..tail one slot
// up, then writes the value at p; delete returns word p and moves later words down;
// get reads word p; locate compares every word; clear, unused codes and rejected
// commands finish from idle. Shift and scan move one word per cycle through the RAM's
// single read and write port. Entries are not reset; only words below the length are used.
module positional_list_engine #(
  parameter int unsigned CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [ple_pkg::CMD_W-1:0]     command_i,
  input  logic [ple_pkg::POS_W-1:0]     position_i,
  input  logic [ple_pkg::DATA_W-1:0]    value_i,
  output logic                          done_o,
  output logic [ple_pkg::STATUS_W-1:0]  status_o,
  output logic [ple_pkg::DATA_W-1:0]    data_out_o,
  output logic [ple_pkg::LEN_W-1:0]     found_at_o,
  output logic [ple_pkg::LEN_W-1:0]     count_o
);

  localparam int unsigned AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LIMIT_I = (CAPACITY < ple_pkg::LEN_MAX) ? CAPACITY : ple_pkg::LEN_MAX;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [ple_pkg::DATA_W-1:0]  ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [ple_pkg::DATA_W-1:0]  ram_rdata;

  ple_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .command_i   (command_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .data_out_o  (data_out_o),
    .found_at_o  (found_at_o),
    .count_o     (count_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  ple_ram #(
    .WIDTH (ple_pkg::DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

`ifndef SYNTH
  a_len_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (count_o <= ple_pkg::LEN_W'(LIMIT_I)))
    else $error("list length above capacity");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted command neither running nor done");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ple_pkg::ST_OK) |-> (data_out_o == '0 && found_at_o == '0))
    else $error("failed command returned data");

  a_found_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_at_o != '0) |-> (found_at_o <= count_o))
    else $error("match position beyond list length");
`endif

endmodule

// ===== tb/positional_list_engine_test.sv =====
// Self-checking testbench for positional_list_engine: a queue-fed command driver, a result
// monitor and an in-bench list model that predicts every status, data, match and length.
// Depends on ple_pkg and the positional_list_engine RTL.
module positional_list_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;

  localparam int unsigned LIST_LIMIT   = (CAPACITY_DEF < LEN_MAX) ? CAPACITY_DEF : LEN_MAX;
  localparam int unsigned CMD_CODE_MAX = (1 << CMD_W) - 1;
  localparam int unsigned POS_CODE_MAX = (1 << POS_W) - 1;
  localparam int unsigned RANDOM_OPS   = 1625;
  localparam int unsigned SETTLE_LIMIT = 2000;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
    int unsigned       gap_pct;
    bit                drain;
  } list_op_t;

  typedef struct {
    ple_status_e       status;
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  found;
    logic [LEN_W-1:0]  count;
  } list_reply_t;

  typedef enum int {GROW, SHRINK, MIXED} op_mix_e;

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              start      = 1'b0;
  logic [CMD_W-1:0]  command_i  = '0;
  logic [POS_W-1:0]  position_i = '0;
  logic [DATA_W-1:0] value_i    = '0;
  logic              busy;
  logic              done_o;
  logic [STATUS_W-1:0] status_o;
  logic [DATA_W-1:0] data_out_o;
  logic [LEN_W-1:0]  found_at_o;
  logic [LEN_W-1:0]  count_o;

  list_op_t    command_backlog[$];
  list_reply_t predicted_replies[$];
  list_op_t    presented_op;
  bit          transfer_seen = 1'b0;
  int unsigned mismatches    = 0;
  int unsigned replies_seen  = 0;

  // model state
  logic [DATA_W-1:0] list_words [CAPACITY_DEF];
  int                list_len = 0;

  // generator's view of the length, used only to aim positions
  int plan_len = 0;

  positional_list_engine dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .command_i  (command_i),
    .position_i (position_i),
    .value_i    (value_i),
    .done_o     (done_o),
    .status_o   (status_o),
    .data_out_o (data_out_o),
    .found_at_o (found_at_o),
    .count_o    (count_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic list_reply_t apply_list_command(input list_op_t op);
    list_reply_t r;
    int p;
    r.status = ST_OK;
    r.data   = '0;
    r.found  = '0;
    p = int'(op.pos);
    case (op.cmd)
      CMD_INSERT: begin
        if (p < 1 || p > list_len + 1) begin
          r.status = ST_BAD_POS;
        end else if (list_len >= int'(LIST_LIMIT)) begin
          r.status = ST_FULL;
        end else begin
          for (int k = list_len; k >= p; k--) list_words[k] = list_words[k-1];
          list_words[p-1] = op.value;
          list_len++;
        end
      end
      CMD_DELETE: begin
        if (p < 1 || p > list_len) begin
          r.status = ST_BAD_POS;
        end else begin
          r.data = list_words[p-1];
          for (int k = p; k < list_len; k++) list_words[k-1] = list_words[k];
          list_len--;
        end
      end
      CMD_GET: begin
        if (p < 1 || p > list_len) r.status = ST_BAD_POS;
        else r.data = list_words[p-1];
      end
      CMD_LOCATE: begin
        r.status = ST_NOT_FOUND;
        for (int k = 0; k < list_len; k++) begin
          if (list_words[k] == op.value) begin
            r.found  = LEN_W'(k + 1);
            r.status = ST_OK;
            break;
          end
        end
      end
      CMD_CLEAR: list_len = 0;
      default: ;
    endcase
    r.count = LEN_W'(list_len);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at reply %0d, %s: got %0h, expected %0h", replies_seen, what, got, want);
    mismatches++;
  endtask

  task automatic queue_op(input logic [CMD_W-1:0] cmd, input int pos,
                          input logic [DATA_W-1:0] value, input int unsigned gap_pct,
                          input bit drain);
    list_op_t op;
    op.cmd     = cmd;
    op.pos     = POS_W'(pos);
    op.value   = value;
    op.gap_pct = gap_pct;
    op.drain   = drain;
    command_backlog.push_back(op);
    case (cmd)
      CMD_INSERT: if (pos >= 1 && pos <= plan_len + 1 && plan_len < int'(LIST_LIMIT)) plan_len++;
      CMD_DELETE: if (pos >= 1 && pos <= plan_len) plan_len--;
      CMD_CLEAR:  plan_len = 0;
      default: ;
    endcase
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] pool [8];
    pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_002A};
    if ($urandom_range(1) == 0) return pool[$urandom_range(7)];
    return $urandom;
  endfunction

  // aim at a legal slot most of the time, anywhere in the field otherwise
  function automatic int pick_position(input int hi);
    if (hi >= 1 && $urandom_range(99) < 85) return $urandom_range(hi, 1);
    return $urandom_range(POS_CODE_MAX);
  endfunction

  always @(negedge clk_i) begin : driver
    list_op_t op;
    bit       issue;
    if (rst_ni && (!start || transfer_seen)) begin
      issue = 1'b0;
      if (command_backlog.size() != 0) begin
        op = command_backlog[0];
        issue = !(op.drain && predicted_replies.size() != 0) &&
                ($urandom_range(99) >= op.gap_pct);
      end
      if (issue) begin
        op = command_backlog.pop_front();
        presented_op <= op;
        command_i    <= op.cmd;
        position_i   <= op.pos;
        value_i      <= op.value;
      end
      start <= issue;
    end
  end

  always @(posedge clk_i) begin : monitor
    list_reply_t want;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (predicted_replies.size() == 0) begin
          report_mismatch("reply with nothing outstanding", status_o, 0);
        end else begin
          want = predicted_replies.pop_front();
          if (status_o !== want.status)   report_mismatch("status", status_o, want.status);
          if (data_out_o !== want.data)   report_mismatch("data_out", data_out_o, want.data);
          if (found_at_o !== want.found)  report_mismatch("found_at", found_at_o, want.found);
          if (count_o !== want.count)     report_mismatch("count", count_o, want.count);
        end
        replies_seen++;
      end
      transfer_seen = start && (busy === 1'b0);
      if (transfer_seen) predicted_replies.push_back(apply_list_command(presented_op));
    end else begin
      transfer_seen = 1'b0;
    end
  end

  initial begin
    #5ms;
    $display("positional_list_engine_test: FAIL");
    $finish;
  end

  initial begin
    op_mix_e     mix;
    int unsigned gap;
    int unsigned left_in_run;
    int unsigned roll;
    int unsigned ins_cut;
    int unsigned del_cut;
    int          waited;

    // directed: empty list, extremes, edges of the insert and get position ranges, unused codes
    queue_op(CMD_INSERT, 0, 32'h0000_0005, 0, 1'b0);
    queue_op(CMD_GET, 1, '0, 0, 1'b0);
    queue_op(CMD_DELETE, 1, '0, 0, 1'b0);
    queue_op(CMD_LOCATE, 0, '0, 0, 1'b0);
    queue_op(CMD_INSERT, 1, 32'h8000_0000, 0, 1'b0);
    queue_op(CMD_INSERT, 2, 32'h7FFF_FFFF, 0, 1'b0);
    queue_op(CMD_INSERT, 4, 32'h1234_5678, 0, 1'b0);
    queue_op(CMD_INSERT, POS_CODE_MAX, 32'h1234_5678, 0, 1'b0);
    queue_op(CMD_INSERT, 2, 32'hFFFF_FFFF, 0, 1'b0);
    queue_op(CMD_INSERT, 1, 32'h0000_0000, 0, 1'b0);
    queue_op(CMD_GET, 4, '0, 0, 1'b0);
    queue_op(CMD_GET, 0, '0, 0, 1'b0);
    queue_op(CMD_GET, 5, '0, 0, 1'b0);
    queue_op(CMD_INSERT, 5, 32'hFFFF_FFFF, 0, 1'b0);
    queue_op(CMD_LOCATE, 0, 32'hFFFF_FFFF, 0, 1'b0);
    queue_op(CMD_DELETE, 2, '0, 0, 1'b0);
    queue_op(CMD_DELETE, 4, '0, 0, 1'b0);
    queue_op(CMD_DELETE, POS_CODE_MAX, '0, 0, 1'b0);
    queue_op(CMD_W'(CMD_CLEAR + 1), 1, 32'h0000_0001, 0, 1'b0);
    queue_op(CMD_W'(CMD_CLEAR + 2), 2, 32'hFFFF_FFFF, 0, 1'b0);
    queue_op(CMD_W'(CMD_CODE_MAX), POS_CODE_MAX, 32'hFFFF_FFFF, 0, 1'b0);
    queue_op(CMD_CLEAR, 0, '0, 0, 1'b1);
    queue_op(CMD_GET, 1, '0, 0, 1'b0);
    queue_op(CMD_LOCATE, 0, 32'h0000_0000, 0, 1'b0);

    // random runs biased toward growing, shrinking or churning the list
    mix = MIXED;
    gap = 0;
    left_in_run = 0;
    for (int i = 0; i < int'(RANDOM_OPS); i++) begin
      if (left_in_run == 0) begin
        left_in_run = $urandom_range(60, 10);
        case ($urandom_range(2))
          0: mix = GROW;
          1: mix = SHRINK;
          default: mix = MIXED;
        endcase
        if (i < 400) gap = 0;
        else if (i < 800) gap = 75;
        else if (i < 1200) gap = 15;
        else gap = ($urandom_range(1) == 0) ? 0 : 75;
      end
      left_in_run--;
      case (mix)
        GROW:    begin ins_cut = 74; del_cut = 84; end
        SHRINK:  begin ins_cut = 19; del_cut = 74; end
        default: begin ins_cut = 39; del_cut = 69; end
      endcase
      roll = $urandom_range(99);
      if (roll < 2)
        queue_op(CMD_CLEAR, $urandom_range(POS_CODE_MAX), pick_value(), gap, i % 150 == 149);
      else if (roll < 4)
        queue_op(CMD_W'($urandom_range(CMD_CODE_MAX, CMD_CLEAR + 1)),
                 $urandom_range(POS_CODE_MAX), $urandom, gap, i % 150 == 149);
      else if (roll < ins_cut)
        queue_op(CMD_INSERT, pick_position(plan_len + 1), pick_value(), gap, i % 150 == 149);
      else if (roll < del_cut)
        queue_op(CMD_DELETE, pick_position(plan_len), pick_value(), gap, i % 150 == 149);
      else if (roll < del_cut + (100 - del_cut) / 2)
        queue_op(CMD_GET, pick_position(plan_len), pick_value(), gap, i % 150 == 149);
      else
        queue_op(CMD_LOCATE, $urandom_range(POS_CODE_MAX), pick_value(), gap, i % 150 == 149);
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (command_backlog.size() != 0 || start) @(posedge clk_i);
    waited = 0;
    while (predicted_replies.size() != 0 && waited < int'(SETTLE_LIMIT)) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (32) @(posedge clk_i);
    if (predicted_replies.size() != 0)
      report_mismatch("replies never delivered", 0, predicted_replies.size());

    if (mismatches == 0) begin
      $display("positional_list_engine_test: PASS");
    end else begin
      $display("positional_list_engine_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/ple_pkg.sv
src/ple_ram.sv
src/ple_ctrl.sv
src/positional_list_engine.sv
tb/positional_list_engine_test.sv
